>>> src/fractional_delay_line_cubic_top_assert.svh
// ----------------------------------------------------------------------------
// fractional delay line assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_DELAY_LINE_CUBIC_TOP_ASSERT_SVH
`define FRACTIONAL_DELAY_LINE_CUBIC_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define FDLC_ASSERT_SAME(lbl, clk, dis, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (dis) (pre) |-> (post)) \
      else $error("fdlc port check failed");

// condition holds in the cycle after the trigger
`define FDLC_ASSERT_NEXT(lbl, clk, dis, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (dis) (pre) |=> (post)) \
      else $error("fdlc port check failed");

`endif

>>> src/fdlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlc_pkg
// shared types and constants of the fractional delay line
// ----------------------------------------------------------------------------
package fdlc_pkg;

   localparam int SAMPLE_W = 24;
   localparam int DELAY_W  = 24;
   localparam int SPM_W    = 16;
   // working width of the cubic coefficients and horner accumulator
   localparam int CW       = 29;

   localparam logic [SPM_W-1:0] SPM_RESET = 16'd12288;

   localparam int SAT_MAX = 8388607;
   localparam int SAT_MIN = -8388608;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_CLAMP,
      ST_POS,
      ST_FETCH,
      ST_LAST,
      ST_HMUL,
      ST_HADD,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic [DELAY_W-1:0]         delay_ms;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       delay_clamped;
   } rsp_type;

endpackage

>>> src/fdlc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlc_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fdlc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/fractional_delay_line_cubic_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_delay_line_cubic_top
// circular audio delay line with a catmull-rom cubic fractional read
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat carries an opcode, a q1.23 sample and a q12.12
//   delay in ms. write stores the sample at the write pointer and advances
//   it, read interpolates the sample that far back, clear zeroes the store.
//   rsp channel: one beat per read, the saturated q1.23 sample and a flag
//   set when the delay was clamped to DEPTH-3 samples.
//   csr port: csr_we/csr_wdata load samples_per_ms (unsigned q8.8); write
//   it only while the block is idle, the block does not enforce this.
// sequence
//   a write leaves the block idle, so the next beat is taken right after it.
//   a read steps through delay multiply, clamp, pointer subtract, four
//   reads on the ram read port, coefficient build, then three horner
//   steps on one shared multiplier (multiply, then shift and add) and
//   the rounding step, which loads its rsp beat into the output register.
//   a clear, and every reset, sweeps the ram one entry a cycle, and req_stall
//   stays high until the sweep is through.
// stalls
//   the rsp beat sits in an output register. while the receiver stalls, new
//   writes and clears are still taken; a second read waits in its last
//   cycle until the register frees up.
// ----------------------------------------------------------------------------
module fractional_delay_line_cubic_top #(
   parameter int DEPTH     = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fdlc_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fdlc_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [fdlc_pkg::SPM_W-1:0] csr_wdata
);

   import fdlc_pkg::*;

   // address, fixed point position and product widths
   localparam int AW  = $clog2(DEPTH);
   localparam int FB  = FRAC_BITS;
   localparam int PW  = AW + FB;
   localparam int DW  = 20 + FB;
   localparam int MW  = DELAY_W + SPM_W;
   localparam int XW  = MW + 4;
   localparam int RSH = 24 - FB;
   localparam int HW  = CW + FB + 1;

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [DW-1:0] DMAX = DW'(DEPTH - 3) << FB;
   localparam logic [PW:0]   SPAN = (PW + 1)'(DEPTH) << FB;

   // control state
   state_type           state_ff, state_in;
   logic [AW-1:0]       wp_ff;
   logic [AW-1:0]       clr_addr_ff;
   logic [SPM_W-1:0]    spm_ff;
   logic [1:0]          fetch_cnt_ff;
   logic [1:0]          step_ff;
   logic                rsp_valid_ff;

   // read datapath
   logic [DELAY_W-1:0]         delay_ff;
   logic [MW-1:0]              mprod_ff;
   logic [PW-1:0]              dcl_ff;
   logic                       clamped_ff;
   logic [AW-1:0]              base_ff;
   logic [FB-1:0]              t_ff;
   logic signed [SAMPLE_W-1:0] y0_ff, y1_ff, y2_ff;
   logic signed [CW-1:0]       acc_ff, c2_ff, c1_ff, y1x2_ff;
   logic signed [HW-1:0]       hprod_ff;
   rsp_type                    rsp_ff;

   // ram side
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [SAMPLE_W-1:0] ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic [SAMPLE_W-1:0] ram_rdata;

   logic                req_accept;
   logic                rsp_free;
   logic [AW-1:0]       wp_next;

   logic [XW-1:0]       d_full;
   logic [DW-1:0]       d_val;
   logic                d_over;
   logic [DW-1:0]       d_clamp;
   logic [PW:0]         pos_diff;
   logic [PW:0]         pos_wrap;
   logic [PW-1:0]       pos;
   logic [AW-1:0]       tap_addr;

   logic signed [CW-1:0] sy0, sy1, sy2, sy3, sd12;
   logic signed [CW-1:0] c1_val, c2_val, c3_val;
   logic signed [HW-1:0] hprod_val;
   logic signed [HW-1:0] hprod_sh;
   logic signed [CW-1:0] coef_sel;
   logic signed [CW-1:0] acc_next;
   logic signed [CW-1:0] rnd;
   logic signed [SAMPLE_W-1:0] sat_val;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign wp_next    = (wp_ff == LAST) ? '0 : wp_ff + 1'b1;

   // delay in samples, floored to FB fraction bits, then clamped
   assign d_full  = {mprod_ff, 4'b0000} >> RSH;
   assign d_val   = d_full[DW-1:0];
   assign d_over  = d_val > DMAX;
   assign d_clamp = d_over ? DMAX : d_val;

   // read point behind the write pointer, wrapped into the circular span
   assign pos_diff = {1'b0, wp_ff, {FB{1'b0}}} - {1'b0, dcl_ff};
   assign pos_wrap = pos_diff + SPAN;
   assign pos      = pos_diff[PW] ? pos_wrap[PW-1:0] : pos_diff[PW-1:0];

   // neighbor taps at offsets -1, 0, +1, +2 around the base index
   always_comb begin
      case (fetch_cnt_ff)
         2'd0:    tap_addr = (base_ff == '0) ? LAST : base_ff - 1'b1;
         2'd1:    tap_addr = base_ff;
         2'd2:    tap_addr = (base_ff == LAST) ? '0 : base_ff + 1'b1;
         default: begin
            if (base_ff == LAST) begin
               tap_addr = AW'(1);
            end else if (base_ff == LAST - 1'b1) begin
               tap_addr = '0;
            end else begin
               tap_addr = base_ff + AW'(2);
            end
         end
      endcase
   end

   // doubled catmull-rom coefficients, y3 straight off the ram port
   assign sy0    = CW'(y0_ff);
   assign sy1    = CW'(y1_ff);
   assign sy2    = CW'(y2_ff);
   assign sy3    = CW'($signed(ram_rdata));
   assign sd12   = sy1 - sy2;
   assign c1_val = sy2 - sy0;
   assign c2_val = (sy0 <<< 1) - ((sy1 <<< 2) + sy1) + (sy2 <<< 2) - sy3;
   assign c3_val = (sy3 - sy0) + ((sd12 <<< 1) + sd12);

   // one horner step: multiply, then floor-shift and add
   assign hprod_val = acc_ff * $signed({1'b0, t_ff});
   assign hprod_sh  = hprod_ff >>> FB;

   always_comb begin
      case (step_ff)
         2'd0:    coef_sel = c2_ff;
         2'd1:    coef_sel = c1_ff;
         default: coef_sel = y1x2_ff;
      endcase
   end

   assign acc_next = CW'(hprod_sh) + coef_sel;

   // final halving rounds half up, then saturates to q1.23
   assign rnd = (acc_ff + CW'(1)) >>> 1;

   always_comb begin
      if (rnd > CW'(SAT_MAX)) begin
         sat_val = SAMPLE_W'(SAT_MAX);
      end else if (rnd < CW'(SAT_MIN)) begin
         sat_val = SAMPLE_W'(SAT_MIN);
      end else begin
         sat_val = rnd[SAMPLE_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.opcode)
                  OP_READ:  state_in = ST_MUL;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL:   state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_POS;
         ST_POS:   state_in = ST_FETCH;
         ST_FETCH: begin
            if (fetch_cnt_ff == 2'd3) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST:  state_in = ST_HMUL;
         ST_HMUL:  state_in = ST_HADD;
         ST_HADD: begin
            if (step_ff == 2'd2) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_HMUL;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine: handshake and ram access
   always_comb begin
      req_stall = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = wp_ff;
      ram_wdata = req_data.sample_in;
      ram_re    = 1'b0;
      ram_raddr = tap_addr;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            ram_we    = req_valid && (req_data.opcode == OP_WRITE);
         end
         ST_FETCH: begin
            ram_re = 1'b1;
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         clr_addr_ff  <= '0;
         spm_ff       <= SPM_RESET;
         fetch_cnt_ff <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            spm_ff <= csr_wdata;
         end
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= (clr_addr_ff == LAST) ? '0 : clr_addr_ff + 1'b1;
         end
         if (state_ff == ST_IDLE && req_accept) begin
            if (req_data.opcode == OP_WRITE) begin
               wp_ff <= wp_next;
            end else if (req_data.opcode == OP_CLEAR) begin
               wp_ff       <= '0;
               clr_addr_ff <= '0;
            end
         end
         if (state_ff == ST_FETCH) begin
            fetch_cnt_ff <= fetch_cnt_ff + 1'b1;
         end else begin
            fetch_cnt_ff <= '0;
         end
         if (state_ff == ST_LAST) begin
            step_ff <= '0;
         end else if (state_ff == ST_HADD) begin
            step_ff <= step_ff + 1'b1;
         end
         if (state_ff == ST_FIN && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_accept) begin
         delay_ff <= req_data.delay_ms;
      end
      if (state_ff == ST_MUL) begin
         mprod_ff <= delay_ff * spm_ff;
      end
      if (state_ff == ST_CLAMP) begin
         dcl_ff     <= d_clamp[PW-1:0];
         clamped_ff <= d_over;
      end
      if (state_ff == ST_POS) begin
         base_ff <= pos[PW-1:FB];
         t_ff    <= pos[FB-1:0];
      end
      // each fetch cycle catches the word requested in the previous one
      if (state_ff == ST_FETCH) begin
         case (fetch_cnt_ff)
            2'd1:    y0_ff <= $signed(ram_rdata);
            2'd2:    y1_ff <= $signed(ram_rdata);
            2'd3:    y2_ff <= $signed(ram_rdata);
            default: y0_ff <= y0_ff;
         endcase
      end
      if (state_ff == ST_LAST) begin
         acc_ff  <= c3_val;
         c2_ff   <= c2_val;
         c1_ff   <= c1_val;
         y1x2_ff <= sy1 <<< 1;
      end
      if (state_ff == ST_HMUL) begin
         hprod_ff <= hprod_val;
      end
      if (state_ff == ST_HADD) begin
         acc_ff <= acc_next;
      end
      if (state_ff == ST_FIN && rsp_free) begin
         rsp_ff.sample_out    <= sat_val;
         rsp_ff.delay_clamped <= clamped_ff;
      end
   end

   fdlc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/fdlc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlc_checker
// port level checks of the fractional delay line, bound to the top level
// ----------------------------------------------------------------------------
`include "fractional_delay_line_cubic_top_assert.svh"

module fdlc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input fdlc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fdlc_pkg::rsp_type rsp_data
);

   import fdlc_pkg::*;

   // a stalled result beat stays put
   `FDLC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // reset starts the clearing sweep and drops any pending result
   `FDLC_ASSERT_NEXT(a_reset_sweep, clock, 1'b0, reset, req_stall && !rsp_valid)

   // a clear beat starts the sweep
   `FDLC_ASSERT_NEXT(a_clear_sweep, clock, reset, req_valid && !req_stall && req_data.opcode == OP_CLEAR, req_stall)

   // only a read makes a result
   `FDLC_ASSERT_NEXT(a_no_rsp_from_other, clock, reset, req_valid && !req_stall && req_data.opcode != OP_READ && !rsp_valid, !rsp_valid)

endmodule

bind fractional_delay_line_cubic_top fdlc_checker u_fdlc_checker (.*);

>>> tb/sv/fractional_delay_line_cubic_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_delay_line_cubic_top_tb
// self-checking bench for the cubic fractional delay line. a short scripted
// table covers the field extremes, every opcode, delay clamping, the zero
// rate and cubic overshoot into saturation. random beats follow under several
// sample rates. each read is checked against a known table value or a
// bit-true bench model of the store, write pointer and catmull-rom read.
// ----------------------------------------------------------------------------
module fractional_delay_line_cubic_top_tb;
   import fdlc_pkg::*;

   localparam int DEPTH         = 4096;
   localparam int FRAC_BITS     = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_BEATS   = 100;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES  = 40;
   localparam int MAX_CLEARS    = 12;

   // opcode the block must ignore
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam longint unsigned DMAX  = longint'(DEPTH - 3) << FRAC_BITS;
   localparam longint unsigned SPAN  = longint'(DEPTH) << FRAC_BITS;
   localparam longint unsigned FMASK = (64'd1 << FRAC_BITS) - 64'd1;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_e;
   typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY} stall_mode_e;

   // one scripted step: a req beat, or a rate write between phases
   typedef struct packed {
      row_kind_e        kind;
      req_type          beat;
      logic [SPM_W-1:0] rate;
      logic             has_known;
      rsp_type          known;
   } script_row_t;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic [SPM_W-1:0] csr_wdata = '0;

   fractional_delay_line_cubic_top #(
      .DEPTH     (DEPTH),
      .FRAC_BITS (FRAC_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // bench copy of the delay line
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] line_mem [DEPTH];
   int unsigned                line_wr_ptr = 0;
   logic [SPM_W-1:0]           line_spm    = SPM_RESET;
   rsp_type                    pending_samples [$];

   int          mismatch_count = 0;
   int          cycle_count    = 0;
   bit          valid_held     = 1'b0;
   bit          steady         = 1'b0;
   int          burst_left     = 0;
   int          clears_left    = MAX_CLEARS;
   int          stall_seg      = 0;
   stall_mode_e stall_mode     = STALL_NONE;

   // catmull-rom read at delay_ms behind the write pointer
   function automatic rsp_type interpolate_delayed(input logic [DELAY_W-1:0] delay);
      longint unsigned prod, d, pos;
      longint          t, y0, y1, y2, y3, c1, c2, c3, acc, r;
      int              base;
      logic            clamped;
      rsp_type         res;
      // q12.12 ms times q8.8 rate is q20.20 samples, floored to FRAC_BITS
      prod    = 64'(delay) * 64'(line_spm);
      d       = prod >> (20 - FRAC_BITS);
      clamped = 1'b0;
      if (d > DMAX) begin
         d       = DMAX;
         clamped = 1'b1;
      end
      pos = ((64'(line_wr_ptr) + DEPTH) << FRAC_BITS) - d;
      if (pos >= SPAN) begin
         pos = pos - SPAN;
      end
      base = int'(pos >> FRAC_BITS);
      t    = longint'(pos & FMASK);
      y0   = line_mem[(base + DEPTH - 1) % DEPTH];
      y1   = line_mem[base];
      y2   = line_mem[(base + 1) % DEPTH];
      y3   = line_mem[(base + 2) % DEPTH];
      // doubled coefficients, horner with floored shifts
      c1   = y2 - y0;
      c2   = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      c3   = (y3 - y0) + 3 * (y1 - y2);
      acc  = c3;
      acc  = ((acc * t) >>> FRAC_BITS) + c2;
      acc  = ((acc * t) >>> FRAC_BITS) + c1;
      acc  = ((acc * t) >>> FRAC_BITS) + 2 * y1;
      // halve, rounding half up, then saturate
      r    = (acc + 1) >>> 1;
      if (r > SAT_MAX) begin
         r = SAT_MAX;
      end
      if (r < SAT_MIN) begin
         r = SAT_MIN;
      end
      res.sample_out    = r[SAMPLE_W-1:0];
      res.delay_clamped = clamped;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // random stimulus
   // ---------------------------------------------------------------------
   function automatic logic [DELAY_W-1:0] random_delay();
      longint unsigned target, ms;
      int              roll;
      logic [31:0]     raw;
      roll = $urandom_range(0, 99);
      raw  = $urandom();
      if (roll >= 80 || line_spm == '0) begin
         return raw[DELAY_W-1:0];
      end
      // mostly short delays so reads land on written samples
      if (roll < 50) begin
         target = $urandom_range(0, 64 << FRAC_BITS);
      end else if (roll < 75) begin
         target = $urandom_range(0, 32'(DMAX));
      end else begin
         target = DMAX + $urandom_range(0, 32) - 16;
      end
      ms = (target << (20 - FRAC_BITS)) / line_spm + $urandom_range(0, 1);
      if (ms > 64'hFFFFFF) begin
         ms = 64'hFFFFFF;
      end
      return ms[DELAY_W-1:0];
   endfunction

   function automatic req_type random_beat();
      req_type     b;
      int          roll;
      logic [31:0] raw;
      raw         = $urandom();
      b.sample_in = raw[SAMPLE_W-1:0];
      roll        = $urandom_range(0, 9);
      // full-scale runs push the cubic into saturation
      if (roll == 0) begin
         b.sample_in = 24'h7FFFFF;
      end else if (roll == 1) begin
         b.sample_in = 24'h800000;
      end else if (roll == 2) begin
         b.sample_in = SAMPLE_W'($urandom_range(0, 31) - 16);
      end
      b.delay_ms = random_delay();
      roll       = $urandom_range(0, 99);
      if (roll < 2 && clears_left > 0) begin
         b.opcode    = OP_CLEAR;
         clears_left = clears_left - 1;
      end else if (roll < 6) begin
         b.opcode = OP_NONE;
      end else if (roll < 56) begin
         b.opcode = OP_WRITE;
      end else begin
         b.opcode = OP_READ;
      end
      return b;
   endfunction

   // ---------------------------------------------------------------------
   // req side
   // ---------------------------------------------------------------------
   task automatic send_beat(input req_type beat, input logic has_known, input rsp_type known);
      req_valid  <= 1'b1;
      req_data   <= beat;
      valid_held  = 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      // beat taken at this edge, update the bench copy
      case (beat.opcode)
         OP_WRITE: begin
            line_mem[line_wr_ptr] = beat.sample_in;
            line_wr_ptr           = (line_wr_ptr + 1) % DEPTH;
         end
         OP_READ: begin
            if (has_known) begin
               pending_samples.push_back(known);
            end else begin
               pending_samples.push_back(interpolate_delayed(beat.delay_ms));
            end
         end
         OP_CLEAR: begin
            foreach (line_mem[i]) begin
               line_mem[i] = '0;
            end
            line_wr_ptr = 0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         if (valid_held) begin
            req_valid  <= 1'b0;
            valid_held  = 1'b0;
         end
         repeat (cycles) @(posedge clock);
      end
   endtask

   // bursts of random length with random gaps, no gaps in a steady phase
   task automatic pace();
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         if (!steady) begin
            hold_off($urandom_range(0, 8));
         end
      end
   endtask

   // all reads answered, then room for a trailing write or clear to finish
   task automatic quiesce();
      if (valid_held) begin
         req_valid  <= 1'b0;
         valid_held  = 1'b0;
      end
      while (pending_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic write_rate(input logic [SPM_W-1:0] rate);
      quiesce();
      csr_we    <= 1'b1;
      csr_wdata <= rate;
      @(posedge clock);
      csr_we    <= 1'b0;
      line_spm   = rate;
   endtask

   function automatic script_row_t beat_row(input logic [1:0] op,
                                            input logic [SAMPLE_W-1:0] sample,
                                            input logic [DELAY_W-1:0] delay);
      script_row_t row;
      row                = '0;
      row.kind           = ROW_BEAT;
      row.beat.opcode    = op;
      row.beat.sample_in = sample;
      row.beat.delay_ms  = delay;
      return row;
   endfunction

   function automatic script_row_t known_read(input logic [DELAY_W-1:0] delay,
                                              input logic [SAMPLE_W-1:0] sample,
                                              input logic clamped);
      script_row_t row;
      row                     = beat_row(OP_READ, '0, delay);
      row.has_known           = 1'b1;
      row.known.sample_out    = sample;
      row.known.delay_clamped = clamped;
      return row;
   endfunction

   function automatic script_row_t rate_row(input logic [SPM_W-1:0] rate);
      script_row_t row;
      row      = '0;
      row.kind = ROW_CSR;
      row.rate = rate;
      return row;
   endfunction

   initial begin
      script_row_t      script [];
      logic [SPM_W-1:0] rates [6];
      req_type          beat;
      int               done;

      foreach (line_mem[i]) begin
         line_mem[i] = '0;
      end

      script = '{
         // fresh store reads back zero, longest delay clamps
         known_read(24'h000000, 24'h000000, 1'b0),
         known_read(24'hFFFFFF, 24'h000000, 1'b1),
         beat_row(OP_NONE, 24'h5A5A5A, 24'hA5A5A5),
         beat_row(OP_WRITE, 24'h7FFFFF, 24'h000000),
         beat_row(OP_WRITE, 24'h800000, 24'hFFFFFF),
         beat_row(OP_WRITE, 24'h000001, 24'h000000),
         beat_row(OP_WRITE, 24'hFFFFFF, 24'h000000),
         beat_row(OP_READ, 24'h000000, 24'h000055),
         beat_row(OP_READ, 24'h000000, 24'h000100),
         // one sample per ms from here
         rate_row(16'd256),
         // min max max min, read midway: overshoots past full scale
         beat_row(OP_WRITE, 24'h800000, 24'h000000),
         beat_row(OP_WRITE, 24'h7FFFFF, 24'h000000),
         beat_row(OP_WRITE, 24'h7FFFFF, 24'h000000),
         beat_row(OP_WRITE, 24'h800000, 24'h000000),
         beat_row(OP_READ, 24'h000000, 24'd10240),
         // mirrored, undershoots past negative full scale
         beat_row(OP_WRITE, 24'h7FFFFF, 24'h000000),
         beat_row(OP_WRITE, 24'h800000, 24'h000000),
         beat_row(OP_WRITE, 24'h800000, 24'h000000),
         beat_row(OP_WRITE, 24'h7FFFFF, 24'h000000),
         beat_row(OP_READ, 24'h000000, 24'd10240),
         // exactly DEPTH-3 samples, then just past it
         beat_row(OP_READ, 24'h000000, 24'hFFD000),
         beat_row(OP_READ, 24'h000000, 24'hFFD001),
         // zero rate gives zero delay
         rate_row(16'd0),
         beat_row(OP_READ, 24'h000000, 24'hFFFFFF),
         rate_row(16'hFFFF),
         beat_row(OP_READ, 24'h000000, 24'hFFFFFF),
         beat_row(OP_READ, 24'h000000, 24'h000001),
         beat_row(OP_CLEAR, 24'h7FFFFF, 24'hFFFFFF),
         // cleared store reads back zero
         known_read(24'h000800, 24'h000000, 1'b0)
      };

      rates = '{16'd12288, 16'd11290, 16'd24576, 16'd1, 16'hFFFF, 16'd0};
      rates[5] = $urandom_range(2, 65534);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            write_rate(script[i].rate);
         end else begin
            send_beat(script[i].beat, script[i].has_known, script[i].known);
            pace();
         end
      end

      // random phases, one rate each
      foreach (rates[p]) begin
         write_rate(rates[p]);
         steady = ($urandom_range(0, 3) == 0);
         done   = 0;
         while (done < PHASE_BEATS) begin
            beat = random_beat();
            send_beat(beat, 1'b0, '0);
            if (beat.opcode != OP_NONE) begin
               done = done + 1;
            end
            pace();
         end
      end

      if (valid_held) begin
         req_valid  <= 1'b0;
         valid_held  = 1'b0;
      end
      while (pending_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // rsp side: stall pattern in segments of random length
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_seg == 0) begin
         stall_mode <= stall_mode_e'($urandom_range(0, 2));
         stall_seg  <= $urandom_range(20, 200);
      end else begin
         stall_seg <= stall_seg - 1;
      end
      case (stall_mode)
         STALL_COIN:  rsp_stall <= ($urandom_range(0, 1) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 7) != 0);
         default:     rsp_stall <= 1'b0;
      endcase
   end

   // compare every rsp beat with the oldest predicted read
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $error("rsp beat with no read pending: sample_out %0d delay_clamped %0b",
                   rsp_data.sample_out, rsp_data.delay_clamped);
            mismatch_count = mismatch_count + 1;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_data.sample_out !== want.sample_out) begin
               $error("sample_out: expected %0d, actual %0d",
                      want.sample_out, rsp_data.sample_out);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_data.delay_clamped !== want.delay_clamped) begin
               $error("delay_clamped: expected %0b, actual %0b",
                      want.delay_clamped, rsp_data.delay_clamped);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
